@@ rtl/superpixel_mask_vote_assert.svh @@
// Assertion macros for the superpixel mask vote RTL.
`ifndef SUPERPIXEL_MASK_VOTE_ASSERT_SVH
`define SUPERPIXEL_MASK_VOTE_ASSERT_SVH

// Checks that a condition holds at every clock edge out of reset.
`define SVM_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("superpixel_mask_vote assertion failed");

// Checks that a trigger is followed by a condition on the next edge.
`define SVM_ASSERT_NEXT(name, trig, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error("superpixel_mask_vote assertion failed");

`endif

@@ rtl/svm_pkg.sv @@
// Types and constants shared by the superpixel mask vote block.
package svm_pkg;

	localparam int MAX_LABELS = 2048;
	localparam int LABEL_BITS = 11;
	localparam int COUNT_BITS = 21;
	localparam int SUM_BITS = COUNT_BITS + 1;
	localparam int PURITY_BITS = 4;
	localparam int PROD_BITS = SUM_BITS + PURITY_BITS;
	localparam int EPOCH_BITS = 8;
	localparam int MASK_BITS = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [LABEL_BITS-1:0] LAST_ADDR = LABEL_BITS'(MAX_LABELS - 1);
	localparam logic [PURITY_BITS-1:0] PURITY_RESET = PURITY_BITS'(9);
	localparam logic [PROD_BITS-1:0] VOTE_SCALE = PROD_BITS'(10);
	localparam logic [MASK_BITS-1:0] MASK_FG = MASK_BITS'(1);
	localparam logic [MASK_BITS-1:0] MASK_BG = MASK_BITS'(0);

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_RELABEL = 1'b1;

	typedef struct packed {
		logic kind;
		logic [LABEL_BITS-1:0] label;
		logic [MASK_BITS-1:0] mask_value;
		logic frame_end;
	} pix_t;

	typedef struct packed {
		logic [MASK_BITS-1:0] mask_out;
		logic last_out;
	} res_t;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic [COUNT_BITS-1:0] fg;
		logic [COUNT_BITS-1:0] bg;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic [COUNT_BITS-1:0] fg;
		logic [COUNT_BITS-1:0] bg;
		logic [MASK_BITS-1:0] mask;
		logic last;
	} vote_req_t;

endpackage

@@ rtl/svm_vote_ram.sv @@
// Vote count memory: one write port and one registered read port.
module svm_vote_ram (
	input  logic clk,
	input  logic rd_en,
	input  logic [svm_pkg::LABEL_BITS-1:0] rd_addr,
	output svm_pkg::entry_t rd_data,
	input  logic wr_en,
	input  logic [svm_pkg::LABEL_BITS-1:0] wr_addr,
	input  svm_pkg::entry_t wr_data
);
	import svm_pkg::*;

	entry_t mem [MAX_LABELS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/svm_decide.sv @@
// Purity test stage and output register of the superpixel mask vote block.
module svm_decide (
	input  logic clk,
	input  logic arst_n,
	input  svm_pkg::vote_req_t req,
	input  logic [svm_pkg::PURITY_BITS-1:0] purity,
	output logic adv,
	output logic res_valid,
	input  logic res_stall,
	output svm_pkg::res_t res
);
	import svm_pkg::*;

	logic s2_valid_q;
	vote_req_t req_s2;
	logic out_valid_q;
	res_t out_q;
	logic [SUM_BITS-1:0] sum;
	logic [PROD_BITS-1:0] lim;
	logic [PROD_BITS-1:0] fg_scaled;
	logic [PROD_BITS-1:0] bg_scaled;
	res_t result;

	assign adv = !(out_valid_q && res_stall);

	always_comb begin
		sum = SUM_BITS'(req_s2.fg) + SUM_BITS'(req_s2.bg);
		lim = PROD_BITS'(purity) * PROD_BITS'(sum);
		fg_scaled = PROD_BITS'(req_s2.fg) * VOTE_SCALE;
		bg_scaled = PROD_BITS'(req_s2.bg) * VOTE_SCALE;
		result.last_out = req_s2.last;
		if (bg_scaled > lim) begin
			result.mask_out = MASK_BG;
		end else if (fg_scaled > lim) begin
			result.mask_out = MASK_FG;
		end else begin
			result.mask_out = req_s2.mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= req.valid;
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2 <= req;
			out_q <= result;
		end
	end

	assign res_valid = out_valid_q;
	assign res = out_q;

endmodule

@@ rtl/superpixel_mask_vote.sv @@
// Top level of the superpixel mask vote block: count update, epochs and clearing.
//
// Pixels enter on pix with pix_valid and pix_stall; an item is taken at an edge with
// pix_valid high and pix_stall low. A count pass pixel adds one vote to its label and
// gives no result. A relabel pass pixel gives one result on res, in input order, after
// passing the registers pix_s1, req_s2 and out_q. One item is taken per cycle while
// pix_stall is low; the vote memory is read on the edge that takes an item and
// written back from pix_s1, with the last write forwarded to the next read.
// Each entry carries an 8-bit frame epoch, so tables read as cleared at every frame.
// After reset, and after every 255th frame, a clearing pass sweeps the 2048 entries
// while pix_stall stays high; the frame that wraps the epoch also holds pix_stall
// high through wrap_pend before the pass. The purity register purity_q, in tenths,
// resets to 9 and is written through cfg_valid and cfg_ready, which is always high.
// When res_stall holds a waiting result, the pipeline freezes and pix_stall rises; a
// stalled result does not change.
module superpixel_mask_vote (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  svm_pkg::pix_t pix,
	output logic res_valid,
	input  logic res_stall,
	output svm_pkg::res_t res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [svm_pkg::PURITY_BITS-1:0] cfg_data
);
	import svm_pkg::*;

	logic [PURITY_BITS-1:0] purity_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic clearing_q;
	logic [LABEL_BITS-1:0] clr_addr_q;
	logic s1_valid_q;
	pix_t pix_s1;
	logic fwd_valid_q;
	logic [LABEL_BITS-1:0] fwd_addr_q;
	entry_t fwd_data_q;

	logic adv;
	logic accept;
	logic wrap_pend;
	logic frame_done;
	logic count_wr;
	entry_t rd_data;
	entry_t cur;
	entry_t upd;
	logic [COUNT_BITS-1:0] fg;
	logic [COUNT_BITS-1:0] bg;
	logic wr_en;
	logic [LABEL_BITS-1:0] wr_addr;
	entry_t wr_data;
	vote_req_t req;

	assign cfg_ready = 1'b1;

	assign frame_done = s1_valid_q && pix_s1.kind == KIND_RELABEL && pix_s1.frame_end;
	assign wrap_pend = frame_done && epoch_q == EPOCH_MAX;
	assign pix_stall = clearing_q || !adv || wrap_pend;
	assign accept = pix_valid && !pix_stall;
	assign count_wr = s1_valid_q && pix_s1.kind == KIND_COUNT && adv;

	always_comb begin
		if (fwd_valid_q && fwd_addr_q == pix_s1.label) begin
			cur = fwd_data_q;
		end else begin
			cur = rd_data;
		end
		if (cur.epoch == epoch_q) begin
			fg = cur.fg;
			bg = cur.bg;
		end else begin
			fg = '0;
			bg = '0;
		end
		upd.epoch = epoch_q;
		upd.fg = fg;
		upd.bg = bg;
		if (pix_s1.mask_value == MASK_FG) begin
			if (fg != COUNT_MAX) begin
				upd.fg = fg + COUNT_BITS'(1);
			end
		end else begin
			if (bg != COUNT_MAX) begin
				upd.bg = bg + COUNT_BITS'(1);
			end
		end
	end

	always_comb begin
		wr_en = clearing_q || count_wr;
		if (clearing_q) begin
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_addr = pix_s1.label;
			wr_data = upd;
		end
	end

	assign req.valid = s1_valid_q && pix_s1.kind == KIND_RELABEL;
	assign req.fg = fg;
	assign req.bg = bg;
	assign req.mask = pix_s1.mask_value;
	assign req.last = pix_s1.frame_end;

	svm_vote_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (pix.label),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	svm_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.purity    (purity_q),
		.adv       (adv),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			purity_q <= PURITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			purity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			epoch_q <= EPOCH_FIRST;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				s1_valid_q <= accept;
			end
			if (clearing_q) begin
				fwd_valid_q <= 1'b0;
				clr_addr_q <= clr_addr_q + LABEL_BITS'(1);
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end else if (count_wr) begin
				fwd_valid_q <= 1'b1;
			end
			if (frame_done && adv) begin
				if (wrap_pend) begin
					epoch_q <= EPOCH_FIRST;
					clearing_q <= 1'b1;
					clr_addr_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
		end
		if (count_wr) begin
			fwd_addr_q <= pix_s1.label;
			fwd_data_q <= upd;
		end
	end

`include "superpixel_mask_vote_assert.svh"

	`SVM_ASSERT(a_clear_stalls, !clearing_q || pix_stall)
	`SVM_ASSERT(a_clear_stage_empty, !clearing_q || !s1_valid_q)
	`SVM_ASSERT(a_epoch_nonzero, epoch_q != '0)
	`SVM_ASSERT_NEXT(a_wrap_clears, wrap_pend && adv, clearing_q && epoch_q == EPOCH_FIRST)

endmodule

@@ sim/superpixel_mask_vote_tb.sv @@
// Self-checking testbench for superpixel_mask_vote: two-pass frames checked against a vote predictor.
`timescale 1ns / 100ps

module superpixel_mask_vote_tb;
	import svm_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int WRAP_FRAMES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PURITY_BITS-1:0] cfg_data = '0;

	logic [COUNT_BITS-1:0] fg_count [MAX_LABELS];
	logic [COUNT_BITS-1:0] bg_count [MAX_LABELS];
	int count_frame [MAX_LABELS] = '{default: -1};
	int frame_no = 0;
	logic [PURITY_BITS-1:0] purity = PURITY_RESET;
	res_t refined_q [$];

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int gap_mode = 0;
	int stall_mode = 0;
	int stall_left = 0;
	bit hold_request = 1'b0;

	superpixel_mask_vote dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
			$display("** superpixel_mask_vote: FAILED **");
			$finish;
		end
	end

	// Counts for a label belong to the frame in which they were last written;
	// counts left from an earlier frame read as zero.
	function automatic void refine_mask(input pix_t p);
		res_t r;
		logic [COUNT_BITS-1:0] fg;
		logic [COUNT_BITS-1:0] bg;
		longint lim;
		fg = '0;
		bg = '0;
		if (p.kind == KIND_COUNT) begin
			if (count_frame[p.label] != frame_no) begin
				fg_count[p.label] = '0;
				bg_count[p.label] = '0;
				count_frame[p.label] = frame_no;
			end
			if (p.mask_value == MASK_FG) begin
				if (fg_count[p.label] != COUNT_MAX)
					fg_count[p.label]++;
			end else if (bg_count[p.label] != COUNT_MAX) begin
				bg_count[p.label]++;
			end
			return;
		end
		if (count_frame[p.label] == frame_no) begin
			fg = fg_count[p.label];
			bg = bg_count[p.label];
		end
		lim = longint'(purity) * (longint'(fg) + longint'(bg));
		if (longint'(bg) * 10 > lim)
			r.mask_out = MASK_BG;
		else if (longint'(fg) * 10 > lim)
			r.mask_out = MASK_FG;
		else
			r.mask_out = p.mask_value;
		r.last_out = p.frame_end;
		refined_q.insert(refined_q.size(), r);
		if (p.frame_end)
			frame_no++;
	endfunction

	function automatic pix_t make_pixel(input logic kind, input logic [LABEL_BITS-1:0] label,
			input logic [MASK_BITS-1:0] mask, input logic fend);
		pix_t p;
		p.kind = kind;
		p.label = label;
		p.mask_value = mask;
		p.frame_end = fend;
		return p;
	endfunction

	function automatic logic [LABEL_BITS-1:0] pick_label();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return LAST_ADDR;
			default: return LABEL_BITS'($urandom_range(0, MAX_LABELS - 1));
		endcase
	endfunction

	function automatic logic [MASK_BITS-1:0] pick_mask();
		case ($urandom_range(0, 2))
			0: return MASK_FG;
			1: return MASK_BG;
			default: return MASK_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input pix_t p);
		int gap;
		gap = 0;
		if (gap_mode != 0 && $urandom_range(0, 99) < (gap_mode == 1 ? 10 : 35))
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall !== 1'b0) @(posedge clk);
		refine_mask(p);
		items_sent++;
	endtask

	task automatic wait_results();
		pix_valid <= 1'b0;
		while (refined_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_purity(input logic [PURITY_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		purity = value;
	endtask

	// One frame: a count pass over a few labels with a chosen foreground share,
	// then a relabel pass, with some stray count items and stray end marks.
	task automatic send_frame(input int n_count, input int n_relabel, input bit broken);
		logic [LABEL_BITS-1:0] pool [4];
		int fg_pct [4];
		int k;
		int i;
		int j;
		pix_t p;
		k = $urandom_range(1, 4);
		for (i = 0; i < 4; i++) begin
			pool[i] = pick_label();
			case ($urandom_range(0, 4))
				0: fg_pct[i] = 0;
				1: fg_pct[i] = 100;
				2: fg_pct[i] = 90;
				3: fg_pct[i] = 50;
				default: fg_pct[i] = $urandom_range(0, 100);
			endcase
		end
		for (i = 0; i < n_count; i++) begin
			j = $urandom_range(0, k - 1);
			p.kind = KIND_COUNT;
			p.label = pool[j];
			if ($urandom_range(0, 99) < fg_pct[j])
				p.mask_value = MASK_FG;
			else
				p.mask_value = $urandom_range(0, 1) ? MASK_BG : MASK_BITS'($urandom_range(0, 255));
			if (i == n_count - 1)
				p.frame_end = 1'($urandom_range(0, 1));
			else
				p.frame_end = ($urandom_range(0, 19) == 0);
			send_pixel(p);
		end
		for (i = 0; i < n_relabel; i++) begin
			j = $urandom_range(0, k - 1);
			if ($urandom_range(0, 14) == 0)
				send_pixel(make_pixel(KIND_COUNT, pool[j], pick_mask(), 1'b0));
			p.kind = KIND_RELABEL;
			p.label = ($urandom_range(0, 9) == 0) ? pick_label() : pool[j];
			p.mask_value = pick_mask();
			p.frame_end = (i == n_relabel - 1) && !broken;
			send_pixel(p);
		end
	endtask

	task automatic test_directed();
		gap_mode = 0;
		stall_mode = 0;
		repeat (3) send_pixel(make_pixel(KIND_COUNT, '0, MASK_FG, 1'b0));
		send_pixel(make_pixel(KIND_COUNT, LAST_ADDR, 8'd255, 1'b0));
		send_pixel(make_pixel(KIND_COUNT, LAST_ADDR, MASK_BG, 1'b0));
		send_pixel(make_pixel(KIND_COUNT, 11'd5, MASK_FG, 1'b0));
		send_pixel(make_pixel(KIND_COUNT, 11'd5, 8'd2, 1'b0));
		send_pixel(make_pixel(KIND_RELABEL, '0, MASK_BG, 1'b0));
		send_pixel(make_pixel(KIND_RELABEL, LAST_ADDR, MASK_FG, 1'b0));
		send_pixel(make_pixel(KIND_RELABEL, 11'd5, 8'd200, 1'b0));
		// A label that got no votes keeps its byte.
		send_pixel(make_pixel(KIND_RELABEL, 11'd100, 8'd77, 1'b0));
		// An end mark on a count item does not start a new frame.
		send_pixel(make_pixel(KIND_COUNT, '0, MASK_FG, 1'b1));
		// A count item inside the relabel pass still adds its vote.
		send_pixel(make_pixel(KIND_COUNT, 11'd5, MASK_FG, 1'b0));
		send_pixel(make_pixel(KIND_RELABEL, 11'd5, MASK_BG, 1'b0));
		send_pixel(make_pixel(KIND_RELABEL, '0, 8'd9, 1'b1));
		send_pixel(make_pixel(KIND_RELABEL, '0, 8'd123, 1'b1));
		send_pixel(make_pixel(KIND_RELABEL, LAST_ADDR, 8'd255, 1'b0));
		send_pixel(make_pixel(KIND_COUNT, 11'd3, 8'd255, 1'b0));
		send_pixel(make_pixel(KIND_RELABEL, 11'd3, MASK_FG, 1'b1));
		wait_results();
	endtask

	// Thresholds in range, at both ends, and outside the range that never trips.
	task automatic test_purity_settings();
		int settings [9] = '{1, 9, 0, 15, 10, 5, 3, 7, 9};
		int ph;
		int target;
		settings[8] = $urandom_range(0, 15);
		for (ph = 0; ph < 9; ph++) begin
			wait_results();
			write_purity(PURITY_BITS'(settings[ph]));
			gap_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
			stall_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
			target = items_sent + 24;
			while (items_sent < target) begin
				if ($urandom_range(0, 4) == 0)
					send_frame($urandom_range(8, 30), $urandom_range(3, 10), 1'b0);
				else
					send_frame($urandom_range(0, 6), $urandom_range(1, 4),
						$urandom_range(0, 9) == 0);
			end
		end
		wait_results();
	endtask

	task automatic test_stall_pressure();
		int i;
		gap_mode = 0;
		stall_mode = 0;
		@(negedge clk);
		hold_request = 1'b1;
		@(posedge clk);
		for (i = 0; i < 24; i++) begin
			if (i % 2 == 0)
				send_pixel(make_pixel(KIND_COUNT, LABEL_BITS'(i % 6), pick_mask(), 1'b0));
			else
				send_pixel(make_pixel(KIND_RELABEL, LABEL_BITS'(i % 6), pick_mask(), i == 23));
		end
		wait_results();
	endtask

	// Many short frames, enough to carry the frame epoch past its wrap and the
	// clearing pass that follows; stale votes would show on uncounted labels.
	task automatic test_epoch_wrap();
		logic [LABEL_BITS-1:0] pool [4];
		int i;
		for (i = 0; i < 4; i++)
			pool[i] = pick_label();
		write_purity(PURITY_BITS'($urandom_range(1, 9)));
		gap_mode = 1;
		stall_mode = 1;
		while (frame_no < WRAP_FRAMES) begin
			if ($urandom_range(0, 3) == 0)
				send_pixel(make_pixel(KIND_COUNT, pool[$urandom_range(0, 3)], pick_mask(), 1'b0));
			send_pixel(make_pixel(KIND_RELABEL, pool[$urandom_range(0, 3)], pick_mask(), 1'b1));
		end
		wait_results();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (stall_mode != 0 && $urandom_range(0, 99) < (stall_mode == 1 ? 10 : 30)) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (refined_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, mask_out %0d last_out %0b",
					$time, res.mask_out, res.last_out);
			end else begin
				want = refined_q.pop_front();
				if (res.mask_out !== want.mask_out) begin
					errors++;
					$display("%0t: mask_out expected %0d, got %0d",
						$time, want.mask_out, res.mask_out);
				end
				if (res.last_out !== want.last_out) begin
					errors++;
					$display("%0t: last_out expected %0b, got %0b",
						$time, want.last_out, res.last_out);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_purity_settings();
		test_stall_pressure();
		test_epoch_wrap();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("** superpixel_mask_vote: PASSED **");
		else
			$display("** superpixel_mask_vote: FAILED **");
		$finish;
	end

endmodule
